// ----- rtl/rpv_pkg.sv -----
package rpv_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned POS_W      = 17;
    localparam int unsigned CNT_W      = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [POS_W-1:0]  POSITION_MAX = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [BYTE_W-1:0] CTRL_LIMIT   = 8'h20;
    localparam logic [BYTE_W-1:0] DEL_BYTE     = 8'h7f;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 16'd4096;
    localparam logic             REJECT_GLOB_RST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_GLOB = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              has_byte;
        logic              last;
    } item_t;

    typedef struct packed {
        logic              valid;
        item_t             item;
    } stage_t;

    typedef struct packed {
        logic [LEN_W-1:0] max_length;
        logic             reject_glob;
    } cfg_t;

endpackage

// ----- rtl/rpv_ifs.sv -----
interface rpv_item_if;
    logic                           valid;
    logic                           ready;
    logic [rpv_pkg::BYTE_W-1:0]     char_byte;
    logic                           has_byte;
    logic                           last;

    modport source (output valid, output char_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input char_byte, input has_byte, input last,
                    output ready);
endinterface

interface rpv_result_if;
    logic valid;
    logic ready;
    logic path_ok;

    modport source (output valid, output path_ok, input ready);
    modport sink   (input valid, input path_ok, output ready);
endinterface

interface rpv_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rpv_pkg::CFG_IDX_W-1:0]     index;
    logic [rpv_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rpv_cfg_regs.sv -----
module rpv_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    rpv_cfg_if.sink       cfg,
    output rpv_pkg::cfg_t regs
);

    rpv_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.max_length  <= rpv_pkg::MAX_LENGTH_RST;
            regs_reg.reject_glob <= rpv_pkg::REJECT_GLOB_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rpv_pkg::REG_MAX_LENGTH)
                regs_reg.max_length <= cfg.data[rpv_pkg::LEN_W-1:0];
            else if (cfg.index == rpv_pkg::REG_REJECT_GLOB)
                regs_reg.reject_glob <= cfg.data[0];
        end
    end

endmodule

// ----- rtl/rpv_in_stage.sv -----
module rpv_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    rpv_item_if.sink        item,
    input  logic            advance,
    output rpv_pkg::stage_t stage
);

    logic          valid_reg;
    rpv_pkg::item_t item_reg;
    logic          take;

    assign item.ready  = !valid_reg || advance;
    assign take        = item.valid && item.ready;
    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (advance)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_byte <= item.char_byte;
            item_reg.has_byte  <= item.has_byte;
            item_reg.last      <= item.last;
        end
    end

endmodule

// ----- rtl/rpv_check.sv -----
module rpv_check
(
    input  logic            clk,
    input  logic            rst_n,
    input  rpv_pkg::stage_t stage,
    input  rpv_pkg::cfg_t   regs,
    output logic            advance,
    rpv_result_if.source    result
);

    logic [rpv_pkg::POS_W-1:0] position_reg,  position_next;
    logic [rpv_pkg::CNT_W-1:0] seg_len_reg,   seg_len_next;
    logic [rpv_pkg::CNT_W-1:0] seg_dots_reg,  seg_dots_next;
    logic                      first_let_reg, first_let_next;
    logic                      failed_reg,    failed_next;
    logic                      out_valid_reg;
    logic                      path_ok_reg;

    logic [rpv_pkg::POS_W-1:0] pos_upd;
    logic [rpv_pkg::CNT_W-1:0] len_upd;
    logic [rpv_pkg::CNT_W-1:0] dots_upd;
    logic                      let_upd;
    logic                      fail_upd;
    logic                      ok;
    logic [rpv_pkg::BYTE_W-1:0] b;
    logic                      is_letter;
    logic                      is_glob;

    function automatic logic seg_bad(input logic [rpv_pkg::CNT_W-1:0] len,
                                     input logic [rpv_pkg::CNT_W-1:0] dots);
        return (len == 2'd0) || (len == 2'd1 && dots == 2'd1)
            || (len == 2'd2 && dots == 2'd2);
    endfunction

    assign advance        = stage.valid && (!out_valid_reg || result.ready);
    assign result.valid   = out_valid_reg;
    assign result.path_ok = path_ok_reg;

    assign b         = stage.item.char_byte;
    assign is_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    assign is_glob   = b == "*" || b == "?" || b == "[" || b == "]"
                    || b == "{" || b == "}";

    always_comb
    begin
        pos_upd  = position_reg;
        len_upd  = seg_len_reg;
        dots_upd = seg_dots_reg;
        let_upd  = first_let_reg;
        fail_upd = failed_reg;
        if (stage.item.has_byte)
        begin
            if (position_reg == '0)
            begin
                if (b == "/" || b == "\\")
                    fail_upd = 1'b1;
                let_upd = is_letter;
            end
            else if (position_reg == rpv_pkg::POS_W'(1) && first_let_reg && b == ":")
                fail_upd = 1'b1;

            if (b == "/")
            begin
                if (seg_bad(seg_len_reg, seg_dots_reg))
                    fail_upd = 1'b1;
                len_upd  = '0;
                dots_upd = '0;
            end
            else
            begin
                if (b == "\\" || b < rpv_pkg::CTRL_LIMIT || b == rpv_pkg::DEL_BYTE)
                    fail_upd = 1'b1;
                if (seg_len_reg != rpv_pkg::CNT_MAX)
                    len_upd = seg_len_reg + 2'd1;
                if (b == "." && seg_dots_reg != rpv_pkg::CNT_MAX)
                    dots_upd = seg_dots_reg + 2'd1;
            end

            if (regs.reject_glob && is_glob)
                fail_upd = 1'b1;

            if (position_reg != rpv_pkg::POSITION_MAX)
                pos_upd = position_reg + rpv_pkg::POS_W'(1);
        end

        ok = !fail_upd && pos_upd != '0
          && pos_upd <= {1'b0, regs.max_length}
          && !seg_bad(len_upd, dots_upd);

        if (stage.item.last)
        begin
            position_next  = '0;
            seg_len_next   = '0;
            seg_dots_next  = '0;
            first_let_next = 1'b0;
            failed_next    = 1'b0;
        end
        else
        begin
            position_next  = pos_upd;
            seg_len_next   = len_upd;
            seg_dots_next  = dots_upd;
            first_let_next = let_upd;
            failed_next    = fail_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            seg_len_reg   <= '0;
            seg_dots_reg  <= '0;
            first_let_reg <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                position_reg  <= position_next;
                seg_len_reg   <= seg_len_next;
                seg_dots_reg  <= seg_dots_next;
                first_let_reg <= first_let_next;
                failed_reg    <= failed_next;
            end
            if (advance && stage.item.last)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.item.last)
            path_ok_reg <= ok;
    end

endmodule

// ----- rtl/relative_path_validator.sv -----
// Relative path validator.
// item:   one word per path byte (char_byte, has_byte, last). A word with
//         has_byte low adds no byte; last marks the final word.
// result: one word per string, path_ok, issued for every word with last set.
// cfg:    register writes, index 0 max_length, index 1 reject_glob; other
//         indexes are ignored. Always ready; write only while idle.
// Datapath: a last word goes through the input register, then the check
// logic into the result register.
// Throughput: one word per cycle while the result register is free or
// being taken, set by the state update of the check stage.
// Reset clears the per-string state and both valid flags, and loads
// max_length = 4096 and reject_glob = 1.
// When the result receiver stalls, the result register holds its word;
// the input register still takes one more word, then item.ready drops.
module relative_path_validator
(
    input  logic         clk,
    input  logic         rst_n,
    rpv_item_if.sink     item,
    rpv_result_if.source result,
    rpv_cfg_if.sink      cfg
);

    rpv_pkg::cfg_t   regs;
    rpv_pkg::stage_t stage;
    logic            advance;

    rpv_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rpv_in_stage u_in
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    rpv_check u_check
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .regs    (regs),
        .advance (advance),
        .result  (result)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam logic [rpv_pkg::BYTE_W-1:0]    SLASH         = 8'h2f;
    localparam logic [rpv_pkg::BYTE_W-1:0]    BACKSLASH     = 8'h5c;
    localparam logic [rpv_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [rpv_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hff;

    typedef struct packed {
        logic [rpv_pkg::BYTE_W-1:0] ch;
        logic                       hb;
        logic                       lst;
        logic                       typed;
        logic                       ok;
    } dir_row_t;

    logic clk;
    logic rst_n;

    rpv_item_if   item_ch ();
    rpv_result_if res_ch ();
    rpv_cfg_if    cfg_ch ();

    relative_path_validator uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // path checker state
    logic [rpv_pkg::POS_W-1:0] pos          = '0;
    logic [rpv_pkg::CNT_W-1:0] seg_len      = '0;
    logic [rpv_pkg::CNT_W-1:0] seg_dots     = '0;
    logic                      first_letter = 1'b0;
    logic                      fail_flag    = 1'b0;
    logic [rpv_pkg::LEN_W-1:0] max_len_cfg  = rpv_pkg::MAX_LENGTH_RST;
    logic                      glob_cfg     = rpv_pkg::REJECT_GLOB_RST;

    bit pending_ok [$];
    int err_count   = 0;
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;
    int rx_hold_len = 0;

    dir_row_t dir_rows [0:22] = '{
        '{8'h00,   1'b0, 1'b1, 1'b1, 1'b0},   // empty string
        '{8'h41,   1'b0, 1'b0, 1'b0, 1'b0},   // filler word, ignored
        '{"a",     1'b1, 1'b1, 1'b1, 1'b1},
        '{"/",     1'b1, 1'b1, 1'b1, 1'b0},
        '{BACKSLASH, 1'b1, 1'b1, 1'b1, 1'b0},
        '{"C",     1'b1, 1'b0, 1'b0, 1'b0},   // drive prefix
        '{":",     1'b1, 1'b1, 1'b1, 1'b0},
        '{".",     1'b1, 1'b1, 1'b1, 1'b0},
        '{".",     1'b1, 1'b0, 1'b0, 1'b0},
        '{".",     1'b1, 1'b1, 1'b1, 1'b0},
        '{"a",     1'b1, 1'b0, 1'b0, 1'b0},   // trailing slash
        '{"/",     1'b1, 1'b1, 1'b1, 1'b0},
        '{"a",     1'b1, 1'b0, 1'b0, 1'b0},   // wildcard
        '{"*",     1'b1, 1'b1, 1'b1, 1'b0},
        '{8'h7f,   1'b1, 1'b1, 1'b1, 1'b0},
        '{8'hff,   1'b1, 1'b1, 1'b1, 1'b1},
        '{8'h1f,   1'b1, 1'b1, 1'b1, 1'b0},
        '{8'h00,   1'b1, 1'b1, 1'b1, 1'b0},
        '{".",     1'b1, 1'b0, 1'b0, 1'b0},   // three dots is a name
        '{".",     1'b1, 1'b0, 1'b0, 1'b0},
        '{".",     1'b1, 1'b1, 1'b1, 1'b1},
        '{"z",     1'b1, 1'b0, 1'b0, 1'b0},   // closed by a word without byte
        '{8'hff,   1'b0, 1'b1, 1'b1, 1'b1}
    };

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    function automatic logic [rpv_pkg::BYTE_W-1:0] rand_byte(input int unsigned lo,
                                                              input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[rpv_pkg::BYTE_W-1:0];
    endfunction

    function automatic logic [rpv_pkg::CFG_DATA_W-1:0] rand_data(input int unsigned lo,
                                                                  input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[rpv_pkg::CFG_DATA_W-1:0];
    endfunction

    function automatic bit seg_rejected();
        return seg_len == 0 || (seg_len == 1 && seg_dots == 1) ||
               (seg_len == 2 && seg_dots == 2);
    endfunction

    task automatic take_path_byte(input logic [rpv_pkg::BYTE_W-1:0] b);
        if (pos == 0)
        begin
            if (b == SLASH || b == BACKSLASH)
                fail_flag = 1'b1;
            first_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
        end
        else if (pos == 1 && first_letter && b == ":")
            fail_flag = 1'b1;

        if (b == SLASH)
        begin
            if (seg_rejected())
                fail_flag = 1'b1;
            seg_len  = '0;
            seg_dots = '0;
        end
        else
        begin
            if (b == BACKSLASH || b < rpv_pkg::CTRL_LIMIT || b == rpv_pkg::DEL_BYTE)
                fail_flag = 1'b1;
            if (seg_len != rpv_pkg::CNT_MAX)
                seg_len++;
            if (b == "." && seg_dots != rpv_pkg::CNT_MAX)
                seg_dots++;
        end

        if (glob_cfg && (b inside {"*", "?", "[", "]", "{", "}"}))
            fail_flag = 1'b1;

        if (pos != rpv_pkg::POSITION_MAX)
            pos++;
    endtask

    task automatic predict_word(input rpv_pkg::item_t w, input bit typed,
                                input bit typed_ok);
        bit ok;
        if (w.has_byte)
            take_path_byte(w.char_byte);
        if (w.last)
        begin
            ok = !fail_flag && pos != 0 && pos <= {1'b0, max_len_cfg} && !seg_rejected();
            pending_ok.push_back(typed ? typed_ok : ok);
            pos          = '0;
            seg_len      = '0;
            seg_dots     = '0;
            first_letter = 1'b0;
            fail_flag    = 1'b0;
        end
    endtask

    task automatic send_word(input rpv_pkg::item_t w, input bit typed, input bit typed_ok);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.char_byte <= w.char_byte;
        item_ch.has_byte  <= w.has_byte;
        item_ch.last      <= w.last;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        predict_word(w, typed, typed_ok);
    endtask

    // call only right after a word was accepted
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_ok.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpv_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == rpv_pkg::REG_MAX_LENGTH)
            max_len_cfg = val;
        else if (idx == rpv_pkg::REG_REJECT_GLOB)
            glob_cfg = val[0];
        @(posedge clk);
    endtask

    function automatic logic [rpv_pkg::BYTE_W-1:0] glob_byte();
        case ($urandom_range(0, 5))
            0:       return "*";
            1:       return "?";
            2:       return "[";
            3:       return "]";
            4:       return "{";
            default: return "}";
        endcase
    endfunction

    function automatic logic [rpv_pkg::BYTE_W-1:0] name_byte();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6, 7: return "a" + rand_byte(0, 25);
            8, 9:                   return "A" + rand_byte(0, 25);
            10:                     return "0" + rand_byte(0, 9);
            11:                     return ".";
            12:                     return $urandom_range(0, 1) ? "-" : "_";
            13:                     return rand_byte(8'h80, 8'hff);
            14:                     return glob_byte();
            default:                return rand_byte(8'h20, 8'h7e);
        endcase
    endfunction

    task automatic send_random_path(output int counted);
        logic [rpv_pkg::BYTE_W-1:0] path [$];
        int   nseg;
        int   seglen;
        bit   close_on_byte;
        rpv_pkg::item_t w;
        counted = 0;
        if ($urandom_range(0, 9) < 7)
        begin
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++)
            begin
                if (s > 0)
                    path.push_back(SLASH);
                case ($urandom_range(0, 15))
                    0: path.push_back(".");
                    1: begin path.push_back("."); path.push_back("."); end
                    2: begin path.push_back("."); path.push_back("."); path.push_back("."); end
                    default:
                    begin
                        seglen = $urandom_range(1, 5);
                        repeat (seglen) path.push_back(name_byte());
                    end
                endcase
            end
        end
        else
        begin
            nseg = $urandom_range(0, 8);
            repeat (nseg) path.push_back(rand_byte(0, 255));
        end

        case ($urandom_range(0, 11))
            0: path.push_front($urandom_range(0, 1) ? BACKSLASH : SLASH);
            1: path.push_back(SLASH);
            2: if (path.size() > 0) path[$urandom_range(0, path.size() - 1)] = rand_byte(0, 255);
            3: if (path.size() > 0) path[$urandom_range(0, path.size() - 1)] = glob_byte();
            4:
            begin
                path.push_front(":");
                path.push_front($urandom_range(0, 1) ? "A" + rand_byte(0, 25)
                                                     : "a" + rand_byte(0, 25));
            end
            5: if (path.size() > 1) path.insert($urandom_range(1, path.size() - 1), SLASH);
            default: ;
        endcase

        close_on_byte = $urandom_range(0, 3) != 0;
        foreach (path[i])
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                w = '{char_byte: rand_byte(0, 255), has_byte: 1'b0, last: 1'b0};
                send_word(w, 1'b0, 1'b0);
            end
            w.char_byte = path[i];
            w.has_byte  = 1'b1;
            w.last      = close_on_byte && i == path.size() - 1;
            send_word(w, 1'b0, 1'b0);
            counted++;
        end
        if (path.size() == 0 || !close_on_byte)
        begin
            w = '{char_byte: rand_byte(0, 255), has_byte: 1'b0, last: 1'b1};
            send_word(w, 1'b0, 1'b0);
            counted++;
        end
    endtask

    task automatic run_random(input int n_words);
        int done;
        int k;
        done = 0;
        while (done < n_words)
        begin
            send_random_path(k);
            done += k;
        end
    endtask

    task automatic send_long_path(input int n, input bit want);
        rpv_pkg::item_t w;
        for (int i = 0; i < n; i++)
        begin
            w.char_byte = "a" + rand_byte(0, 25);
            w.has_byte  = 1'b1;
            w.last      = i == n - 1;
            send_word(w, 1'b1, want);
        end
    endtask

    // result side: random stalls, plus a long hold when asked
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                stall = rx_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (res_ch.valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_ok.size() == 0)
                report_mismatch($sformatf("path_ok word %b with nothing pending",
                                          res_ch.path_ok));
            else
            begin
                want = pending_ok.pop_front();
                if (res_ch.path_ok !== want)
                    report_mismatch($sformatf("path_ok %b, predicted %b",
                                              res_ch.path_ok, want));
            end
        end
    end

    initial
    begin
        rpv_pkg::item_t w;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.char_byte = '0;
        item_ch.has_byte  = 1'b0;
        item_ch.last      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i <= 22; i++)
        begin
            w = '{char_byte: dir_rows[i].ch, has_byte: dir_rows[i].hb,
                  last: dir_rows[i].lst};
            send_word(w, dir_rows[i].typed, dir_rows[i].ok);
        end
        settle();

        write_reg(rpv_pkg::REG_REJECT_GLOB, 16'd0);
        write_reg(rpv_pkg::REG_MAX_LENGTH, rand_data(4, 16));
        run_random(250);
        // long result stall while words keep coming
        tx_idle = 1'b0;
        rx_hold_len = 60;
        run_random(150);
        settle();
        tx_idle = 1'b1;
        run_random(150);
        settle();

        write_reg(REG_UNUSED_LO, rand_data(0, 65535));
        write_reg(REG_UNUSED_HI, rand_data(0, 65535));
        write_reg(rpv_pkg::REG_MAX_LENGTH, 16'd1);
        write_reg(rpv_pkg::REG_REJECT_GLOB, 16'd1);
        rx_idle = 1'b0;
        run_random(150);
        settle();

        write_reg(rpv_pkg::REG_MAX_LENGTH, 16'd0);
        rx_idle = 1'b1;
        run_random(60);
        settle();

        // length limit boundary
        write_reg(rpv_pkg::REG_MAX_LENGTH, 16'd20);
        write_reg(rpv_pkg::REG_REJECT_GLOB, 16'd0);
        tx_idle = 1'b0;
        send_long_path(20, 1'b1);
        send_long_path(21, 1'b0);
        settle();

        write_reg(rpv_pkg::REG_MAX_LENGTH, 16'hffff);
        run_random(150);
        settle();

        rx_idle = 1'b0;
        write_reg(rpv_pkg::REG_MAX_LENGTH, rand_data(2, 24));
        write_reg(rpv_pkg::REG_REJECT_GLOB, 16'd1);
        run_random(300);
        settle();

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(rpv_pkg::REG_MAX_LENGTH, rpv_pkg::MAX_LENGTH_RST);
        run_random(300);
        settle();
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
